FILE: sv/jmef_pkg.sv
// jmef_pkg: shared types, codes and helpers for the jpeg marker end finder
// used by jmef_parser, jmef_out_skid and jpeg_marker_end_finder; no dependencies

package jmef_pkg;

   localparam int DataWidth   = 8;
   localparam int StatusWidth = 2;
   localparam int OffsetWidth = 32;
   localparam int RspWidth    = 40;
   localparam int LenWidth    = 16;

   localparam logic [7:0] ByteFill = 8'hFF;
   localparam logic [7:0] ByteSoi  = 8'hD8;
   localparam logic [7:0] ByteEoi  = 8'hD9;
   localparam logic [7:0] ByteSos  = 8'hDA;

   localparam logic [LenWidth-1:0] SofHeaderBytes = 16'd5;
   localparam logic [9:0]          SofFixedLength = 10'd8;
   localparam logic [LenWidth-1:0] MinSegLength   = 16'd2;

   typedef enum logic [3:0] {
      PH_FIRST0    = 4'd0,
      PH_FIRST1    = 4'd1,
      PH_SEEK      = 4'd2,
      PH_MARKER    = 4'd3,
      PH_LEN_HI    = 4'd4,
      PH_LEN_LO    = 4'd5,
      PH_SKIP      = 4'd6,
      PH_SOF_HDR   = 4'd7,
      PH_SOF_NCOMP = 4'd8,
      PH_SCAN      = 4'd9,
      PH_SCAN_MARK = 4'd10
   } phase_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_END       = 2'd0,
      ST_BAD_START = 2'd1,
      ST_BAD_LEN   = 2'd2,
      ST_EARLY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [OffsetWidth-1:0] end_offset;
      status_type             status;
   } rsp_item_type;

   localparam int RspItemWidth = $bits(rsp_item_type);

   function automatic logic is_sofn(input logic [7:0] m);
      is_sofn = (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
   endfunction

endpackage

FILE: sv/jmef_parser.sv
// jmef_parser: marker segment walker state, one byte per accepted transaction
// depends on jmef_pkg

module jmef_parser #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output logic                  emit,
   output jmef_pkg::rsp_item_type item
);
   import jmef_pkg::*;

   phase_type                 phase_ff, phase_in, phase_step;
   logic [OFFSET_WIDTH-1:0]   count_ff, count_in, count_inc;
   logic [LenWidth-1:0]       seg_rem_ff, seg_rem_in, seg_rem_dec;
   logic [7:0]                len_hi_ff, len_hi_in;
   logic [LenWidth-1:0]       frame_len_ff, frame_len_in;
   logic [7:0]                marker_ff, marker_in;
   logic                      finished_ff, finished_in;

   logic [LenWidth-1:0]       seg_len;
   logic [9:0]                comp_bytes;
   logic                      sof_match;
   logic                      step;
   logic                      step_emit;
   status_type                step_status;
   logic [63:0]               count_wide;
   logic [OffsetWidth-1:0]    offset_sat;

   assign step        = accept && !finished_ff;
   assign seg_len     = {len_hi_ff, data_byte};
   assign comp_bytes  = 10'(data_byte) + 10'({data_byte, 1'b0});
   assign sof_match   = frame_len_ff == LenWidth'(comp_bytes + SofFixedLength);
   assign seg_rem_dec = (seg_rem_ff != '0) ? seg_rem_ff - 1'b1 : seg_rem_ff;
   assign count_inc   = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign count_wide  = 64'(count_inc);
   assign offset_sat  = (count_wide[63:32] != '0) ? '1 : count_wide[31:0];

   // next phase
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_FIRST0: phase_step = PH_FIRST1;
         PH_FIRST1: begin
            if (len_hi_ff == ByteFill && data_byte == ByteSoi) phase_step = PH_SEEK;
         end
         PH_SEEK: begin
            if (data_byte == ByteFill) phase_step = PH_MARKER;
         end
         PH_MARKER: begin
            if (data_byte == ByteSos) phase_step = PH_SCAN;
            else if (data_byte != ByteFill && data_byte != ByteEoi) phase_step = PH_LEN_HI;
         end
         PH_LEN_HI: phase_step = PH_LEN_LO;
         PH_LEN_LO: begin
            if (is_sofn(marker_ff)) phase_step = PH_SOF_HDR;
            else if (seg_len == MinSegLength) phase_step = PH_SEEK;
            else if (seg_len > MinSegLength) phase_step = PH_SKIP;
         end
         PH_SKIP: begin
            if (seg_rem_dec == '0) phase_step = PH_SEEK;
         end
         PH_SOF_HDR: begin
            if (seg_rem_dec == '0) phase_step = PH_SOF_NCOMP;
         end
         PH_SOF_NCOMP: begin
            if (sof_match) phase_step = (comp_bytes == '0) ? PH_SEEK : PH_SKIP;
         end
         PH_SCAN: begin
            if (data_byte == ByteFill) phase_step = PH_SCAN_MARK;
         end
         PH_SCAN_MARK: begin
            if (data_byte != ByteFill && data_byte != ByteEoi) phase_step = PH_SCAN;
         end
         default: phase_step = PH_SEEK;
      endcase

      phase_in = phase_ff;
      if (step) phase_in = phase_step;
      if (accept && last_byte) phase_in = PH_FIRST0;
   end

   // result of one step
   always_comb begin
      step_emit   = 1'b0;
      step_status = ST_END;
      case (phase_ff)
         PH_FIRST1: begin
            if (!(len_hi_ff == ByteFill && data_byte == ByteSoi)) begin
               step_emit   = 1'b1;
               step_status = ST_BAD_START;
            end
         end
         PH_MARKER, PH_SCAN_MARK: begin
            if (data_byte == ByteEoi) begin
               step_emit   = 1'b1;
               step_status = ST_END;
            end
         end
         PH_LEN_LO: begin
            if (!is_sofn(marker_ff) && seg_len < MinSegLength) begin
               step_emit   = 1'b1;
               step_status = ST_BAD_LEN;
            end
         end
         PH_SOF_NCOMP: begin
            if (!sof_match) begin
               step_emit   = 1'b1;
               step_status = ST_BAD_LEN;
            end
         end
         default: begin
            step_emit   = 1'b0;
            step_status = ST_END;
         end
      endcase

      emit            = step && (step_emit || last_byte);
      item.end_offset = '0;
      if (step_emit) begin
         item.status = step_status;
         if (step_status == ST_END) item.end_offset = offset_sat;
      end else if (phase_step == PH_FIRST0 || phase_step == PH_FIRST1) begin
         item.status = ST_BAD_START;
      end else begin
         item.status = ST_EARLY;
      end
   end

   // datapath registers
   always_comb begin
      count_in     = count_ff;
      seg_rem_in   = seg_rem_ff;
      len_hi_in    = len_hi_ff;
      frame_len_in = frame_len_ff;
      marker_in    = marker_ff;
      finished_in  = finished_ff;
      if (step) begin
         count_in    = count_inc;
         finished_in = step_emit;
         case (phase_ff)
            PH_FIRST0, PH_LEN_HI: len_hi_in = data_byte;
            PH_MARKER: begin
               if (data_byte != ByteFill && data_byte != ByteEoi && data_byte != ByteSos)
                  marker_in = data_byte;
            end
            PH_LEN_LO: begin
               if (is_sofn(marker_ff)) begin
                  frame_len_in = seg_len;
                  seg_rem_in   = SofHeaderBytes;
               end else if (seg_len >= MinSegLength) begin
                  seg_rem_in = seg_len - MinSegLength;
               end
            end
            PH_SKIP, PH_SOF_HDR: seg_rem_in = seg_rem_dec;
            PH_SOF_NCOMP: begin
               if (sof_match) seg_rem_in = LenWidth'(comp_bytes);
            end
            default: seg_rem_in = seg_rem_ff;
         endcase
      end
      if (accept && last_byte) begin
         count_in     = '0;
         seg_rem_in   = '0;
         len_hi_in    = '0;
         frame_len_in = '0;
         marker_in    = '0;
         finished_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST0;
         count_ff     <= '0;
         seg_rem_ff   <= '0;
         len_hi_ff    <= '0;
         frame_len_ff <= '0;
         marker_ff    <= '0;
         finished_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         seg_rem_ff   <= seg_rem_in;
         len_hi_ff    <= len_hi_in;
         frame_len_ff <= frame_len_in;
         marker_ff    <= marker_in;
         finished_ff  <= finished_in;
      end
   end

   a_quiet_after_result: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !emit)
      else $error("result after the parser finished");

   a_finish_on_result: assert property (@(posedge clock) disable iff (reset)
      (emit && !last_byte) |=> finished_ff)
      else $error("parser not finished after a result");

   a_restart_on_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (phase_ff == PH_FIRST0 && !finished_ff && count_ff == '0))
      else $error("parser did not restart after the last byte");

   a_end_on_eoi: assert property (@(posedge clock) disable iff (reset)
      (emit && item.status == ST_END) |-> (data_byte == ByteEoi))
      else $error("end reported on a byte other than the end marker");

endmodule

FILE: sv/jmef_out_skid.sv
// jmef_out_skid: result register with a skid entry between parser and rsp channel
// depends on jmef_pkg

module jmef_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  jmef_pkg::rsp_item_type push_item,
   output logic                   can_take,
   output logic                   out_valid,
   input  logic                   out_ready,
   output jmef_pkg::rsp_item_type out_item
);
   import jmef_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         pop;

   assign pop       = out_valid_ff && out_ready;
   assign can_take  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = push;
            skid_item_in  = push_item;
         end else begin
            out_valid_in = push;
            out_item_in  = push_item;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while the output register is empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && skid_valid_ff) |-> pop)
      else $error("result pushed into a full buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (out_valid_ff && out_item_ff == $past(skid_item_ff)))
      else $error("skid entry lost on drain");

endmodule

FILE: sv/jpeg_marker_end_finder.sv
// jpeg_marker_end_finder: top level, one JPEG byte per transaction in, status and end offset out
// depends on jmef_pkg, jmef_parser and jmef_out_skid
// each result is registered in the output register, or in its skid entry while that is held
// throughput: one byte per cycle while req_tready is high
// req_tready drops only while both the result register and its skid entry are full
// reset (synchronous, active high) returns the parser to expecting the start marker

module jpeg_marker_end_finder #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [33:2] end_offset, [39:34] zero
);
   import jmef_pkg::*;

   logic         accept;
   logic         emit;
   logic         can_take;
   rsp_item_type step_item;
   rsp_item_type rsp_item;

   assign req_tready = can_take;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tdata  = {(RspWidth - RspItemWidth)'(0), rsp_item};

   jmef_parser #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .emit      (emit),
      .item      (step_item)
   );

   jmef_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_item (step_item),
      .can_take  (can_take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

endmodule

FILE: tb/sv/tb_jpeg_marker_end_finder.sv
// tb_jpeg_marker_end_finder: self-checking testbench for the jpeg marker end finder
// holds a scoreboard class that predicts each status and end offset from the accepted bytes
// depends on jmef_pkg and the jpeg_marker_end_finder top level

import jmef_pkg::*;

function automatic bit is_frame_marker(input logic [7:0] m);
   // c0..cf, less the three non-frame codes c4, c8 and cc
   return (m[7:4] == 4'hC) && !((m[1:0] == 2'b00) && (m[3:2] != 2'b00));
endfunction

class marker_walk_board;
   phase_type              phase;
   logic [OffsetWidth-1:0] byte_count;
   logic [LenWidth-1:0]    seg_left;
   logic [7:0]             held_byte;
   logic [LenWidth-1:0]    frame_len;
   logic [7:0]             marker;
   bit                     done;
   rsp_item_type           awaited_reports[$];
   int                     errors;

   function new();
      restart();
      errors = 0;
   endfunction

   function void restart();
      phase      = PH_FIRST0;
      byte_count = '0;
      seg_left   = '0;
      held_byte  = '0;
      frame_len  = '0;
      marker     = '0;
      done       = 1'b0;
   endfunction

   function int pending();
      return awaited_reports.size();
   endfunction

   task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   function void note_byte(input logic [7:0] b, input logic last);
      logic [LenWidth-1:0]    seg_len;
      logic [LenWidth-1:0]    comp_bytes;
      bit                     emit;
      status_type             st;
      logic [OffsetWidth-1:0] off;
      rsp_item_type           item;
      emit = 1'b0;
      st   = ST_END;
      off  = '0;
      if (!done) begin
         if (byte_count != '1) byte_count++;
         case (phase)
            PH_FIRST0: begin
               held_byte = b;
               phase     = PH_FIRST1;
            end
            PH_FIRST1: begin
               if (held_byte == ByteFill && b == ByteSoi) phase = PH_SEEK;
               else begin
                  emit = 1'b1;
                  st   = ST_BAD_START;
               end
            end
            PH_SEEK: begin
               if (b == ByteFill) phase = PH_MARKER;
            end
            PH_MARKER: begin
               if (b == ByteFill) begin
                  // fill byte, stay put
               end else if (b == ByteEoi) begin
                  emit = 1'b1;
                  st   = ST_END;
                  off  = byte_count;
               end else if (b == ByteSos) begin
                  phase = PH_SCAN;
               end else begin
                  marker = b;
                  phase  = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               held_byte = b;
               phase     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               seg_len = {held_byte, b};
               if (is_frame_marker(marker)) begin
                  frame_len = seg_len;
                  seg_left  = SofHeaderBytes;
                  phase     = PH_SOF_HDR;
               end else if (seg_len < MinSegLength) begin
                  emit = 1'b1;
                  st   = ST_BAD_LEN;
               end else begin
                  seg_left = seg_len - MinSegLength;
                  phase    = (seg_left == '0) ? PH_SEEK : PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (seg_left != '0) seg_left--;
               if (seg_left == '0) phase = PH_SEEK;
            end
            PH_SOF_HDR: begin
               if (seg_left != '0) seg_left--;
               if (seg_left == '0) phase = PH_SOF_NCOMP;
            end
            PH_SOF_NCOMP: begin
               comp_bytes = LenWidth'(b) * LenWidth'(3);
               if (frame_len != LenWidth'(SofFixedLength) + comp_bytes) begin
                  emit = 1'b1;
                  st   = ST_BAD_LEN;
               end else begin
                  seg_left = comp_bytes;
                  phase    = (comp_bytes == '0) ? PH_SEEK : PH_SKIP;
               end
            end
            PH_SCAN: begin
               if (b == ByteFill) phase = PH_SCAN_MARK;
            end
            PH_SCAN_MARK: begin
               if (b == ByteEoi) begin
                  emit = 1'b1;
                  st   = ST_END;
                  off  = byte_count;
               end else if (b != ByteFill) begin
                  phase = PH_SCAN;
               end
            end
            default: begin
               phase = PH_SEEK;
            end
         endcase
         if (emit) done = 1'b1;
         else if (last) begin
            emit = 1'b1;
            st   = (phase == PH_FIRST0 || phase == PH_FIRST1) ? ST_BAD_START : ST_EARLY;
         end
      end
      if (last) restart();
      if (emit) begin
         item.status     = st;
         item.end_offset = off;
         awaited_reports.push_back(item);
      end
   endfunction

   task check_report(input logic [RspWidth-1:0] word);
      rsp_item_type want;
      rsp_item_type got;
      got = rsp_item_type'(word[RspItemWidth-1:0]);
      if (awaited_reports.size() == 0) begin
         report_mismatch("unexpected result", 64'(word), 64'(0));
         return;
      end
      want = awaited_reports.pop_front();
      if (got.status != want.status)
         report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.end_offset != want.end_offset)
         report_mismatch("end_offset", 64'(got.end_offset), 64'(want.end_offset));
      if (word[RspWidth-1:RspItemWidth] != '0)
         report_mismatch("padding", 64'(word[RspWidth-1:RspItemWidth]), 64'(0));
   endtask
endclass

module tb_jpeg_marker_end_finder;

   localparam int CycleLimit   = 300000;
   localparam int HoldCycles   = 400;
   localparam int PhaseItems   = 300;
   localparam int DirectedSize = 23;

   localparam logic [7:0] StuffByte = 8'h00;
   localparam logic [7:0] RstMarker = 8'hD0;

   localparam logic [7:0] DirectedBytes [DirectedSize] = '{
      8'h00,
      8'hFF, 8'hD8, 8'hFF, 8'hDA, 8'h12, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hD9,
      8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h01, 8'hFF,
      8'hFF, 8'hD8, 8'hFF,
      8'hFF, 8'h00
   };
   localparam logic [DirectedSize-1:0] DirectedLast =
      (23'd1 << 0) | (23'd1 << 10) | (23'd1 << 17) | (23'd1 << 20) | (23'd1 << 22);

   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspWidth-1:0] rsp_tdata;

   marker_walk_board board;
   byte_item_type    byte_stream[$];
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   logic             hold_kick      = 1'b0;
   int               hold_left      = 0;
   int               cycle_count    = 0;

   jpeg_marker_end_finder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: check each transaction, random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_report(rsp_tdata);
         if (hold_kick) hold_left <= HoldCycles;
         else if (hold_left != 0) hold_left <= hold_left - 1;
         rsp_tready <= !hold_kick && (hold_left == 0) &&
                       ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b, last);
   endtask

   task automatic send_stream();
      byte_item_type it;
      while (byte_stream.size() != 0) begin
         it = byte_stream.pop_front();
         send_byte(it.data, it.last);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic add_random_file();
      logic [7:0]    file_q[$];
      int            kind;
      int            nseg;
      int            n;
      int            cut;
      logic [7:0]    m;
      logic [15:0]   len;
      logic [7:0]    ncomp;
      byte_item_type it;
      kind = $urandom_range(99, 0);
      if (kind >= 92) begin
         // noise buffer
         n = $urandom_range(8, 1);
         repeat (n) file_q.push_back(8'($urandom_range(255, 0)));
         if ($urandom_range(1, 0) == 1) file_q[0] = ByteFill;
      end else begin
         file_q.push_back(ByteFill);
         file_q.push_back(ByteSoi);
         if (kind < 4) file_q[$urandom_range(1, 0)] = 8'($urandom_range(254, 0));
         nseg = $urandom_range(3, 0);
         for (int s = 0; s < nseg; s++) begin
            if ($urandom_range(3, 0) == 0)
               repeat ($urandom_range(3, 1)) file_q.push_back(8'($urandom_range(254, 0)));
            repeat ($urandom_range(2, 1)) file_q.push_back(ByteFill);
            if ($urandom_range(3, 0) == 0) begin
               do m = 8'($urandom_range(8'hCF, 8'hC0)); while (!is_frame_marker(m));
               ncomp = 8'($urandom_range(4, 0));
               len   = 16'd8 + 16'd3 * 16'(ncomp);
               if (kind >= 84) len = len + 16'($urandom_range(3, 1));
               file_q.push_back(m);
               file_q.push_back(len[15:8]);
               file_q.push_back(len[7:0]);
               repeat (5) file_q.push_back(8'($urandom_range(255, 0)));
               file_q.push_back(ncomp);
               repeat (3 * ncomp) file_q.push_back(8'($urandom_range(255, 0)));
            end else begin
               do m = 8'($urandom_range(254, 0));
               while (m == ByteEoi || m == ByteSos || is_frame_marker(m));
               if ($urandom_range(19, 0) == 0) len = 16'($urandom_range(300, 256));
               else len = 16'($urandom_range(9, 2));
               if (kind >= 76 && kind < 84 && s == nseg - 1) len = 16'($urandom_range(1, 0));
               file_q.push_back(m);
               file_q.push_back(len[15:8]);
               file_q.push_back(len[7:0]);
               if (len >= MinSegLength)
                  repeat (len - MinSegLength) file_q.push_back(8'($urandom_range(255, 0)));
            end
         end
         file_q.push_back(ByteFill);
         if ($urandom_range(4, 0) == 0) file_q.push_back(ByteEoi);
         else begin
            file_q.push_back(ByteSos);
            n = $urandom_range(16, 0);
            repeat (n) begin
               file_q.push_back(8'($urandom_range(254, 0)));
               if ($urandom_range(5, 0) == 0) begin
                  file_q.push_back(ByteFill);
                  if ($urandom_range(1, 0) == 1) file_q.push_back(StuffByte);
                  else file_q.push_back(RstMarker + 8'($urandom_range(7, 0)));
               end
            end
            repeat ($urandom_range(2, 1)) file_q.push_back(ByteFill);
            file_q.push_back(ByteEoi);
         end
         repeat ($urandom_range(2, 0)) file_q.push_back(8'($urandom_range(255, 0)));
      end
      cut = file_q.size();
      if ($urandom_range(9, 0) == 0) cut = $urandom_range(file_q.size(), 1);
      for (int i = 0; i < cut; i++) begin
         it.data = file_q[i];
         it.last = (i == cut - 1);
         byte_stream.push_back(it);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      recv_stall_pct <= stall_pct;
      send_idle_pct = idle_pct;
      while (byte_stream.size() < count) add_random_file();
      send_stream();
      drain();
   endtask

   task automatic run_directed();
      byte_item_type it;
      for (int i = 0; i < DirectedSize; i++) begin
         it.data = DirectedBytes[i];
         it.last = DirectedLast[i];
         byte_stream.push_back(it);
      end
      send_stream();
      drain();
   endtask

   task automatic run_pressure();
      byte_item_type it;
      recv_stall_pct <= 0;
      send_idle_pct = 0;
      // one-byte buffers each give a result, so the output fills quickly
      repeat (60) begin
         it.data = 8'($urandom_range(255, 0));
         it.last = 1'b1;
         byte_stream.push_back(it);
      end
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      send_stream();
      drain();
      while (byte_stream.size() < 40) add_random_file();
      send_stream();
      drain();
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_phase(0, 0, PhaseItems);
      run_phase(63, 0, PhaseItems);
      run_phase(0, 63, PhaseItems);
      run_phase(15, 15, PhaseItems);
      run_pressure();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
sv/jmef_pkg.sv
sv/jmef_parser.sv
sv/jmef_out_skid.sv
sv/jpeg_marker_end_finder.sv
tb/sv/tb_jpeg_marker_end_finder.sv
